/* rtl/mpq_pkg.sv */
// Package: shared widths, constants, lookup tables and the back-end state type.
package mpq_pkg;

  localparam int unsigned MAX_LEN_DEFAULT = 65536;
  localparam int unsigned SCORE_W         = 7;
  localparam int unsigned TOP_Q           = 93;
  localparam int unsigned FRAC_BITS       = 44;
  // An error probability of 1.0 needs one integer bit on top of the fraction.
  localparam int unsigned PROB_W          = FRAC_BITS + 1;
  localparam int unsigned LO_W            = 23;
  localparam int unsigned HI_W            = PROB_W - LO_W;
  localparam logic [SCORE_W-1:0] MAXQ_RESET = SCORE_W'(41);
  localparam logic [SCORE_W-1:0] TOP_SCORE  = SCORE_W'(TOP_Q);

  localparam logic [63:0] ONE_E18 = 64'd1000000000000000000;

  // 10^(-j/20) for j = 0..19, scaled by 10^18.
  localparam logic [0:19][63:0] HALF_DB_STEP = '{
    64'd1000000000000000000, 64'd891250938133745600, 64'd794328234724281500,
    64'd707945784384137900, 64'd630957344480193200, 64'd562341325190349100,
    64'd501187233627272200, 64'd446683592150963150, 64'd398107170553497200,
    64'd354813389233575470, 64'd316227766016837940, 64'd281838293126445370,
    64'd251188643150957960, 64'd223872113856833950, 64'd199526231496887970,
    64'd177827941003892300, 64'd158489319246111340, 64'd141253754462275450,
    64'd125892541179416730, 64'd112201845430196360
  };

  typedef logic [TOP_Q:0][PROB_W-1:0] prob_tbl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_COMPARE,
    BK_EMIT
  } bk_state_e;

  // Shift-subtract division, evaluated only while the tables are elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(10^(-s/20) * 2^44) for s in 0..199.
  function automatic logic [63:0] tenth_power(input int unsigned s);
    int unsigned idx;
    int unsigned dec;
    logic [63:0] c;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] dv;
    int          i;
    idx = s % 20;
    dec = s / 20;
    c   = HALF_DB_STEP[idx];
    q   = c / ONE_E18;
    r   = c % ONE_E18;
    dv  = 64'd1;
    for (i = 0; i < 60; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ONE_E18) begin
        r    = r - ONE_E18;
        q[0] = 1'b1;
      end
    end
    for (i = 0; i < int'(dec); i++) begin
      dv = dv * 64'd10;
    end
    dv = dv << (60 - FRAC_BITS);
    return udiv64(q + (dv >> 1), dv);
  endfunction

  // Error probability of each base quality.
  function automatic prob_tbl_t build_err_tbl();
    prob_tbl_t   t;
    logic [63:0] v;
    int          k;
    for (k = 0; k <= int'(TOP_Q); k++) begin
      v    = tenth_power(2 * k);
      t[k] = v[PROB_W-1:0];
    end
    return t;
  endfunction

  // Rounding boundary between mean k-1 and k; entry 0 is never read.
  function automatic prob_tbl_t build_bnd_tbl();
    prob_tbl_t   t;
    logic [63:0] v;
    int          k;
    t[0] = '0;
    for (k = 1; k <= int'(TOP_Q); k++) begin
      v    = tenth_power(2 * k - 1);
      t[k] = v[PROB_W-1:0];
    end
    return t;
  endfunction

  localparam prob_tbl_t ERR_TBL = build_err_tbl();
  localparam prob_tbl_t BND_TBL = build_bnd_tbl();

endpackage

/* rtl/mean_phred_quality_core.sv */
// Top level: mean Phred quality of a read, averaged in error-probability space.
// Usage: drive one base per beat by raising start_i while busy_o is low; a beat with
// last_i high closes the read, and the beat is taken whether or not has_score_i is set.
// The front end accepts a base every cycle while busy_o is low. When a read closes, its
// totals go into a two-entry queue and the front end starts on the next read at once;
// busy_o is high only while that queue holds two unfinished reads. The back end turns
// each read into a result by a linear search over the rounding boundaries, with one
// shared 17x23-bit multiplier used twice per boundary tried. Each result appears for
// exactly one cycle with done_o high and cannot be held off by the receiver. The user
// writes max_quality_i with max_quality_we_i while the block is idle; the block itself
// does not enforce this. Values above 93 act as 93 and a value of 0 forces every mean
// to 0.
module mean_phred_quality_core
  import mpq_pkg::*;
#(
  parameter int unsigned MaxLen = MAX_LEN_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [SCORE_W-1:0] quality_score_i,
  input  logic               has_score_i,
  input  logic               last_i,
  input  logic               max_quality_we_i,
  input  logic [SCORE_W-1:0] max_quality_i,
  output logic               done_o,
  output logic [SCORE_W-1:0] mean_quality_o,
  output logic               empty_res_o,
  output logic               overflow_o
);

  localparam int unsigned CntW   = $clog2(MaxLen + 1);
  localparam int unsigned SumW   = CntW + FRAC_BITS;
  localparam int unsigned EntryW = SumW + CntW + 1;

  logic [SCORE_W-1:0] max_quality_q;

  logic              accept;
  logic              push;
  logic [SumW-1:0]   f_sum;
  logic [CntW-1:0]   f_count;
  logic              f_dropped;
  logic              q_pop, q_full, q_empty;
  logic [EntryW-1:0] q_head;

  // The clamp register; the back end samples it when it picks up a read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_quality_q <= MAXQ_RESET;
    end else if (max_quality_we_i) begin
      max_quality_q <= max_quality_i;
    end
  end

  // A beat is refused only when the queue cannot take another closed read.
  assign busy_o = q_full;
  assign accept = start_i & ~busy_o;

  mpq_front #(
    .MaxLen (MaxLen)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .quality_score_i (quality_score_i),
    .has_score_i     (has_score_i),
    .last_i          (last_i),
    .push_o          (push),
    .sum_o           (f_sum),
    .count_o         (f_count),
    .dropped_o       (f_dropped)
  );

  mpq_queue #(
    .Width (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_sum, f_count, f_dropped}),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mpq_back #(
    .MaxLen (MaxLen)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_sum_i        (q_head[EntryW-1:CntW+1]),
    .q_count_i      (q_head[CntW:1]),
    .q_dropped_i    (q_head[0]),
    .max_quality_i  (max_quality_q),
    .pop_o          (q_pop),
    .done_o         (done_o),
    .mean_quality_o (mean_quality_o),
    .empty_res_o    (empty_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

/* rtl/mpq_front.sv */
// Front end: accumulates error probabilities and base counts of one read.
module mpq_front
  import mpq_pkg::*;
#(
  parameter int unsigned MaxLen = MAX_LEN_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     accept_i,
  input  logic [SCORE_W-1:0]                       quality_score_i,
  input  logic                                     has_score_i,
  input  logic                                     last_i,
  output logic                                     push_o,
  output logic [$clog2(MaxLen+1)+FRAC_BITS-1:0]    sum_o,
  output logic [$clog2(MaxLen+1)-1:0]              count_o,
  output logic                                     dropped_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned SumW = CntW + FRAC_BITS;

  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               dropped_q, dropped_d;
  logic [SCORE_W-1:0] score_clamped;
  logic [PROB_W-1:0]  prob;
  logic               keep;

  // Scores above the table are treated as the top score.
  assign score_clamped = (quality_score_i > TOP_SCORE) ? TOP_SCORE : quality_score_i;
  assign prob          = ERR_TBL[score_clamped];
  assign keep          = has_score_i && (count_q < CntW'(MaxLen));

  always_comb begin
    sum_d     = keep ? sum_q + SumW'(prob) : sum_q;
    count_d   = keep ? count_q + CntW'(1) : count_q;
    dropped_d = dropped_q | (has_score_i & ~keep);
  end

  // The closing beat hands the totals, including its own base, to the queue.
  assign push_o    = accept_i & last_i;
  assign sum_o     = sum_d;
  assign count_o   = count_d;
  assign dropped_o = dropped_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        sum_q     <= '0;
        count_q   <= '0;
        dropped_q <= 1'b0;
      end else begin
        sum_q     <= sum_d;
        count_q   <= count_d;
        dropped_q <= dropped_d;
      end
    end
  end

endmodule

/* rtl/mpq_queue.sv */
// Two-entry queue that carries finished read totals from the front to the back end.
module mpq_queue
  import mpq_pkg::*;
#(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue read while empty");

endmodule

/* rtl/mpq_back.sv */
// Back end: searches the rounded mean quality of one read against the boundary table.
module mpq_back
  import mpq_pkg::*;
#(
  parameter int unsigned MaxLen = MAX_LEN_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_empty_i,
  input  logic [$clog2(MaxLen+1)+FRAC_BITS-1:0] q_sum_i,
  input  logic [$clog2(MaxLen+1)-1:0]           q_count_i,
  input  logic                                  q_dropped_i,
  input  logic [SCORE_W-1:0]                    max_quality_i,
  output logic                                  pop_o,
  output logic                                  done_o,
  output logic [SCORE_W-1:0]                    mean_quality_o,
  output logic                                  empty_res_o,
  output logic                                  overflow_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned SumW = CntW + FRAC_BITS;
  localparam int unsigned BndW = CntW + PROB_W;

  bk_state_e state_q, state_d;

  logic [SumW-1:0]      sum_q;
  logic [CntW-1:0]      count_q;
  logic                 dropped_q;
  logic [SCORE_W-1:0]   k_q, limit_q, mean_q;
  logic                 empty_q;
  logic [CntW+LO_W-1:0] prod_lo_q;
  logic [CntW+HI_W-1:0] prod_hi_q;

  logic [PROB_W-1:0]    bnd;
  logic [LO_W-1:0]      mul_op;
  logic [CntW+LO_W-1:0] mul_out;
  logic [BndW-1:0]      bound;
  logic                 fits;
  logic                 no_bases;
  logic                 past_limit;

  logic load_en, mul_lo_en, mul_hi_en, step_en, finish_en;

  assign bnd        = BND_TBL[k_q];
  // One multiplier serves both halves of the boundary on consecutive cycles.
  assign mul_op     = mul_hi_en ? LO_W'(bnd[PROB_W-1:LO_W]) : bnd[LO_W-1:0];
  assign mul_out    = (CntW+LO_W)'(count_q) * (CntW+LO_W)'(mul_op);
  assign bound      = {prod_hi_q, {LO_W{1'b0}}} + BndW'(prod_lo_q);
  assign fits       = BndW'(sum_q) <= bound;
  assign no_bases   = (count_q == '0);
  assign past_limit = (k_q > limit_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:    if (!q_empty_i) state_d = BK_CHECK;
      BK_CHECK:   state_d = (no_bases || past_limit) ? BK_EMIT : BK_MUL_LO;
      BK_MUL_LO:  state_d = BK_MUL_HI;
      BK_MUL_HI:  state_d = BK_COMPARE;
      BK_COMPARE: state_d = fits ? BK_CHECK : BK_EMIT;
      BK_EMIT:    state_d = BK_IDLE;
      default:    state_d = BK_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    load_en   = 1'b0;
    mul_lo_en = 1'b0;
    mul_hi_en = 1'b0;
    step_en   = 1'b0;
    finish_en = 1'b0;
    unique case (state_q)
      BK_IDLE:    load_en   = ~q_empty_i;
      BK_CHECK:   finish_en = no_bases | past_limit;
      BK_MUL_LO:  mul_lo_en = 1'b1;
      BK_MUL_HI:  mul_hi_en = 1'b1;
      BK_COMPARE: begin
        step_en   = fits;
        finish_en = ~fits;
      end
      BK_EMIT:    ;
      default:    ;
    endcase
  end

  assign pop_o = load_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      sum_q     <= q_sum_i;
      count_q   <= q_count_i;
      dropped_q <= q_dropped_i;
      k_q       <= SCORE_W'(1);
      limit_q   <= (max_quality_i > TOP_SCORE) ? TOP_SCORE : max_quality_i;
    end
    if (mul_lo_en) begin
      prod_lo_q <= mul_out;
    end
    if (mul_hi_en) begin
      prod_hi_q <= mul_out[CntW+HI_W-1:0];
    end
    if (step_en) begin
      k_q <= k_q + SCORE_W'(1);
    end
    if (finish_en) begin
      mean_q  <= k_q - SCORE_W'(1);
      empty_q <= no_bases;
    end
  end

  assign done_o         = (state_q == BK_EMIT);
  assign mean_quality_o = mean_q;
  assign empty_res_o    = empty_q;
  assign overflow_o     = dropped_q & ~empty_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o && empty_res_o |-> mean_quality_o == '0)
    else $error("empty read reported a nonzero mean");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> mean_quality_o <= limit_q)
    else $error("mean exceeds the clamp");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == BK_MUL_LO |-> k_q >= SCORE_W'(1) && k_q <= limit_q)
    else $error("boundary index out of range");

endmodule
